// ===== sv/pkct_pkg.sv =====
// Package for the partial-key cuckoo table: sizes, entry and row types,
// status and action codes, the seeded hash and the victim LFSR step.
// Depends on nothing; the table and the testbench use it.
package pkct_pkg;

   localparam int BUCKETS = 256;   // power of two
   localparam int WAYS    = 4;     // power of two
   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FP_W    = BKT_W;
   localparam int KICK_W  = 10;
   localparam int SEED_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [31:0] HASH_INIT  = 32'd5381;
   localparam int          HASH_SHIFT = 5;   // multiply by 33 is (h << 5) + h

   localparam logic [KICK_W-1:0] KICK_RESET = 10'd500;
   localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_UPDATE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_GAVE_UP   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_KICKOUTS = 2'd0,
      CSR_FAIL_EAGERLY = 2'd1,
      CSR_RANDOM_SEED  = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic            valid;
      logic [FP_W-1:0] fp;
      logic [31:0]     value;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   function automatic logic [BKT_W-1:0] seeded_hash(input logic seed, input logic [15:0] x);
      logic [31:0] h;
      h = seed ? (HASH_INIT + 32'd1) : 32'd0;
      h = ((h << HASH_SHIFT) + h) ^ {24'd0, x[7:0]};
      h = ((h << HASH_SHIFT) + h) ^ {24'd0, x[15:8]};
      return h[BKT_W-1:0];
   endfunction

   function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
      return {s[0] ^ s[2] ^ s[3] ^ s[5], s[SEED_W-1:1]};
   endfunction

endpackage

// ===== sv/pkct_req_if.sv =====
// Request channel of the cuckoo table: valid/ready plus the request word.
// Depends on nothing.
interface pkct_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] item_key;
   logic [31:0] new_value;

   modport source (output valid, action, item_key, new_value, input ready);
   modport sink   (input valid, action, item_key, new_value, output ready);
endinterface

// ===== sv/pkct_rsp_if.sv =====
// Response channel of the cuckoo table: valid/ready plus the result word.
// Depends on pkct_pkg for nothing but shares its widths.
interface pkct_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] found_value;

   modport source (output valid, status, found_value, input ready);
   modport sink   (input valid, status, found_value, output ready);
endinterface

// ===== sv/partial_key_cuckoo_table.sv =====
// Partial-key cuckoo table: bucket memory, hash and victim LFSR under one sequencer.
// Depends on pkct_pkg, pkct_req_if and pkct_rsp_if.
//
//   channel  | direction | handshake          | contents
//   req_ch   | in        | valid/ready        | action, item_key, new_value
//   rsp_ch   | out       | valid/ready        | status, found_value
//   csr_*    | in        | write enable only  | index, 16-bit data
//
// After reset a clearing pass writes empty rows, one bucket per cycle; no word is
// accepted meanwhile, configuration writes are.
// A delete, lookup, update or insert without relocation steps through hashing, two
// bucket reads on the single read port, a decide-and-write-back step and the load of
// the output register, which raises the response.
// Each relocation adds a victim-bucket read step and a swap step.
// The response sits in an output register; a stalled response holds the
// sequencer in its last step, and a new word is taken once the state is idle.
module partial_key_cuckoo_table (
   input  logic                            clock,
   input  logic                            reset,
   pkct_req_if.sink                        req_ch,
   pkct_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [pkct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pkct_pkg::CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_BKT   = 8'b0000_0100,
      S_RD1   = 8'b0000_1000,
      S_CHK   = 8'b0001_0000,
      S_KRD   = 8'b0010_0000,
      S_KWR   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type                         state_ff, state_in;
   logic [pkct_pkg::BKT_W-1:0]        clr_cnt_ff, clr_cnt_in;
   pkct_pkg::action_type              act_ff, act_in;
   logic [pkct_pkg::FP_W-1:0]         fp_ff, fp_in;
   logic [31:0]                       val_ff, val_in;
   logic [pkct_pkg::BKT_W-1:0]        bk0_ff, bk0_in, bk1_ff, bk1_in;
   logic [pkct_pkg::BKT_W-1:0]        cur_b_ff, cur_b_in;
   pkct_pkg::row_type                 row0_ff, row0_in;
   pkct_pkg::row_type                 rd_row_ff;
   logic [pkct_pkg::WAY_W-1:0]        way_ff, way_in;
   logic [pkct_pkg::KICK_W-1:0]       kick_cnt_ff, kick_cnt_in;
   logic [pkct_pkg::SEED_W-1:0]       lfsr_ff, lfsr_in;
   logic [pkct_pkg::KICK_W-1:0]       max_kick_ff, max_kick_in;
   logic                              fail_eager_ff, fail_eager_in;
   logic [pkct_pkg::SEED_W-1:0]       seed_ff, seed_in;
   pkct_pkg::status_type              res_status_ff, res_status_in;
   logic [31:0]                       res_found_ff, res_found_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   pkct_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [31:0]                       rsp_found_ff, rsp_found_in;

   pkct_pkg::row_type                 mem [pkct_pkg::BUCKETS];
   logic [pkct_pkg::BKT_W-1:0]        rd_addr, wr_addr;
   logic                              wr_en;
   pkct_pkg::row_type                 wr_row;

   // Bucket scan over both candidate rows, first hit in bucket 0 then way order.
   logic                              hit, free;
   logic                              hit_c, free_c;
   logic [pkct_pkg::WAY_W-1:0]        hit_w, free_w;
   pkct_pkg::row_type                 scan [2];
   pkct_pkg::entry_type               old_ent;
   logic [pkct_pkg::SEED_W-1:0]       drawn;
   logic [pkct_pkg::KICK_W:0]         kick_next;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found_value = rsp_found_ff;

   assign scan[0]   = row0_ff;
   assign scan[1]   = rd_row_ff;
   assign old_ent   = rd_row_ff[way_ff];
   assign drawn     = pkct_pkg::lfsr_step(lfsr_ff);
   assign kick_next = {1'b0, kick_cnt_ff} + {{pkct_pkg::KICK_W{1'b0}}, 1'b1};

   always_comb begin
      hit = 1'b0; hit_c = 1'b0; hit_w = '0;
      free = 1'b0; free_c = 1'b0; free_w = '0;
      for (int c = 1; c >= 0; c--) begin
         for (int w = pkct_pkg::WAYS - 1; w >= 0; w--) begin
            if (scan[c][w].valid && scan[c][w].fp == fp_ff) begin
               hit = 1'b1; hit_c = c[0]; hit_w = w[pkct_pkg::WAY_W-1:0];
            end
            if (!scan[c][w].valid) begin
               free = 1'b1; free_c = c[0]; free_w = w[pkct_pkg::WAY_W-1:0];
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      act_in        = act_ff;
      fp_in         = fp_ff;
      val_in        = val_ff;
      bk0_in        = bk0_ff;
      bk1_in        = bk1_ff;
      cur_b_in      = cur_b_ff;
      row0_in       = row0_ff;
      way_in        = way_ff;
      kick_cnt_in   = kick_cnt_ff;
      lfsr_in       = lfsr_ff;
      max_kick_in   = max_kick_ff;
      fail_eager_in = fail_eager_ff;
      seed_in       = seed_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rd_addr       = cur_b_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_b_ff;
      wr_row        = rd_row_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_row     = '0;
            clr_cnt_in = clr_cnt_ff + pkct_pkg::BKT_W'(1);
            if (clr_cnt_ff == pkct_pkg::BKT_W'(pkct_pkg::BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               act_in   = pkct_pkg::action_type'(req_ch.action);
               fp_in    = pkct_pkg::seeded_hash(1'b0, req_ch.item_key[15:0])
                        ^ pkct_pkg::seeded_hash(1'b1, req_ch.item_key[31:16]);
               val_in   = req_ch.new_value;
               state_in = S_BKT;
            end
         end
         S_BKT: begin
            bk0_in   = pkct_pkg::seeded_hash(1'b0, 16'(fp_ff));
            bk1_in   = pkct_pkg::seeded_hash(1'b1, 16'(fp_ff));
            rd_addr  = bk0_in;
            state_in = S_RD1;
         end
         S_RD1: begin
            row0_in  = rd_row_ff;
            rd_addr  = bk1_ff;
            state_in = S_CHK;
         end
         S_CHK: begin
            res_found_in = '0;
            wr_addr      = hit_c ? bk1_ff : bk0_ff;
            wr_row       = scan[hit_c];
            state_in     = S_DONE;
            if (hit) begin
               res_status_in = pkct_pkg::ST_OK;
               case (act_ff)
                  pkct_pkg::ACT_DELETE: begin
                     wr_en = 1'b1;
                     wr_row[hit_w].valid = 1'b0;
                  end
                  pkct_pkg::ACT_LOOKUP: begin
                     res_found_in = scan[hit_c][hit_w].value;
                  end
                  default: begin
                     wr_en = 1'b1;
                     wr_row[hit_w].value = val_ff;
                  end
               endcase
            end else if (act_ff != pkct_pkg::ACT_INSERT) begin
               res_status_in = pkct_pkg::ST_NOT_FOUND;
            end else if (free) begin
               res_status_in = pkct_pkg::ST_OK;
               wr_en   = 1'b1;
               wr_addr = free_c ? bk1_ff : bk0_ff;
               wr_row  = scan[free_c];
               wr_row[free_w] = '{valid: 1'b1, fp: fp_ff, value: val_ff};
            end else if (fail_eager_ff) begin
               res_status_in = pkct_pkg::ST_FULL;
            end else begin
               lfsr_in     = drawn;
               cur_b_in    = drawn[0] ? bk1_ff : bk0_ff;
               kick_cnt_in = '0;
               if (max_kick_ff == '0) begin
                  res_status_in = pkct_pkg::ST_GAVE_UP;
               end else begin
                  state_in = S_KRD;
               end
            end
         end
         S_KRD: begin
            rd_addr  = cur_b_ff;
            lfsr_in  = drawn;
            way_in   = drawn[pkct_pkg::WAY_W-1:0];
            state_in = S_KWR;
         end
         S_KWR: begin
            wr_en   = 1'b1;
            wr_addr = cur_b_ff;
            wr_row[way_ff] = '{valid: 1'b1, fp: fp_ff, value: val_ff};
            res_found_in   = '0;
            if (!old_ent.valid) begin
               res_status_in = pkct_pkg::ST_OK;
               state_in      = S_DONE;
            end else begin
               fp_in  = old_ent.fp;
               val_in = old_ent.value;
               // The displaced entry moves on to its other candidate bucket.
               cur_b_in = (cur_b_ff == pkct_pkg::seeded_hash(1'b0, 16'(old_ent.fp)))
                        ? pkct_pkg::seeded_hash(1'b1, 16'(old_ent.fp))
                        : pkct_pkg::seeded_hash(1'b0, 16'(old_ent.fp));
               kick_cnt_in = kick_next[pkct_pkg::KICK_W-1:0];
               if (kick_next == {1'b0, max_kick_ff}) begin
                  res_status_in = pkct_pkg::ST_GAVE_UP;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_KRD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      if (csr_wr_en) begin
         case (pkct_pkg::csr_index_type'(csr_index))
            pkct_pkg::CSR_MAX_KICKOUTS: max_kick_in   = csr_wdata[pkct_pkg::KICK_W-1:0];
            pkct_pkg::CSR_FAIL_EAGERLY: fail_eager_in = csr_wdata[0];
            pkct_pkg::CSR_RANDOM_SEED: begin
               seed_in = csr_wdata[pkct_pkg::SEED_W-1:0];
               lfsr_in = csr_wdata[pkct_pkg::SEED_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         lfsr_ff       <= pkct_pkg::SEED_RESET;
         max_kick_ff   <= pkct_pkg::KICK_RESET;
         fail_eager_ff <= 1'b0;
         seed_ff       <= pkct_pkg::SEED_RESET;
         rsp_valid_ff  <= 1'b0;
         kick_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         lfsr_ff       <= lfsr_in;
         max_kick_ff   <= max_kick_in;
         fail_eager_ff <= fail_eager_in;
         seed_ff       <= seed_in;
         rsp_valid_ff  <= rsp_valid_in;
         kick_cnt_ff   <= kick_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      fp_ff         <= fp_in;
      val_ff        <= val_in;
      bk0_ff        <= bk0_in;
      bk1_ff        <= bk1_in;
      cur_b_ff      <= cur_b_in;
      row0_ff       <= row0_in;
      way_ff        <= way_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= mem[rd_addr];
   end

`ifndef SYNTHESIS
   a_kick_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KWR) |-> ({1'b0, kick_cnt_ff} < {1'b0, max_kick_ff}))
      else $error("relocation count passed the kickout limit");

   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == S_BKT))
      else $error("accepted word did not start hashing");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the final step");

   a_lookup_only_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && act_ff != pkct_pkg::ACT_LOOKUP) |-> (res_found_ff == '0))
      else $error("found value nonzero for an action other than lookup");
`endif

endmodule

// ===== dv/tb.sv =====
// Testbench for the partial-key cuckoo table: random and directed words, a scoreboard
// with its own mirror of the bucket store and victim LFSR, and random stalls.
// Depends on pkct_pkg, pkct_req_if, pkct_rsp_if and partial_key_cuckoo_table.
`timescale 1ns / 100ps

module tb;

   typedef struct {
      pkct_pkg::status_type status;
      logic [31:0]          found_value;
   } rsp_word_type;

   class cuckoo_mirror;
      bit                                slot_valid [pkct_pkg::BUCKETS*pkct_pkg::WAYS];
      logic [pkct_pkg::FP_W-1:0]         slot_fp    [pkct_pkg::BUCKETS*pkct_pkg::WAYS];
      logic [31:0]                       slot_value [pkct_pkg::BUCKETS*pkct_pkg::WAYS];
      logic [pkct_pkg::SEED_W-1:0]       lfsr;
      logic [pkct_pkg::KICK_W-1:0]       kick_limit;
      bit                                eager;
      rsp_word_type                      expected_rsp [$];
      int                                errors;

      function new();
         foreach (slot_valid[i]) begin
            slot_valid[i] = 0;
            slot_fp[i]    = '0;
            slot_value[i] = '0;
         end
         lfsr       = pkct_pkg::SEED_RESET;
         kick_limit = pkct_pkg::KICK_RESET;
         eager      = 0;
         errors     = 0;
      endfunction

      function void set_reg(pkct_pkg::csr_index_type idx,
                            logic [pkct_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            pkct_pkg::CSR_MAX_KICKOUTS: kick_limit = data[pkct_pkg::KICK_W-1:0];
            pkct_pkg::CSR_FAIL_EAGERLY: eager = data[0];
            pkct_pkg::CSR_RANDOM_SEED:  lfsr = data[pkct_pkg::SEED_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [pkct_pkg::BKT_W-1:0] bucket_hash(bit seed, logic [15:0] x);
         logic [31:0] h;
         h = seed ? 32'd5382 : 32'd0;
         h = (h * 32'd33) ^ {24'd0, x[7:0]};
         h = (h * 32'd33) ^ {24'd0, x[15:8]};
         return h[pkct_pkg::BKT_W-1:0];
      endfunction

      function void advance_lfsr();
         lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[pkct_pkg::SEED_W-1:1]};
      endfunction

      function int find_slot(logic [pkct_pkg::BKT_W-1:0] b0, logic [pkct_pkg::BKT_W-1:0] b1,
                             logic [pkct_pkg::FP_W-1:0] fp);
         int idx;
         for (int c = 0; c < 2; c++)
            for (int w = 0; w < pkct_pkg::WAYS; w++) begin
               idx = int'(c ? b1 : b0) * pkct_pkg::WAYS + w;
               if (slot_valid[idx] && slot_fp[idx] == fp) return idx;
            end
         return -1;
      endfunction

      function pkct_pkg::status_type insert_key(logic [pkct_pkg::BKT_W-1:0] b0,
                                                logic [pkct_pkg::BKT_W-1:0] b1,
                                                logic [pkct_pkg::FP_W-1:0] fp,
                                                logic [31:0] v);
         int hit;
         int idx;
         logic [pkct_pkg::BKT_W-1:0] b;
         logic [pkct_pkg::FP_W-1:0]  old_fp;
         logic [31:0]                old_v;
         hit = find_slot(b0, b1, fp);
         if (hit >= 0) begin
            slot_value[hit] = v;
            return pkct_pkg::ST_OK;
         end
         for (int c = 0; c < 2; c++)
            for (int w = 0; w < pkct_pkg::WAYS; w++) begin
               idx = int'(c ? b1 : b0) * pkct_pkg::WAYS + w;
               if (!slot_valid[idx]) begin
                  slot_valid[idx] = 1;
                  slot_fp[idx]    = fp;
                  slot_value[idx] = v;
                  return pkct_pkg::ST_OK;
               end
            end
         if (eager) return pkct_pkg::ST_FULL;
         advance_lfsr();
         b = lfsr[0] ? b1 : b0;
         for (int n = 0; n < int'(kick_limit); n++) begin
            advance_lfsr();
            idx = int'(b) * pkct_pkg::WAYS + int'(lfsr % pkct_pkg::WAYS);
            old_fp = slot_fp[idx];
            old_v  = slot_value[idx];
            slot_fp[idx]    = fp;
            slot_value[idx] = v;
            if (!slot_valid[idx]) begin
               slot_valid[idx] = 1;
               return pkct_pkg::ST_OK;
            end
            fp = old_fp;
            v  = old_v;
            // The displaced entry goes to whichever of its buckets it is not in now.
            b = (b == bucket_hash(0, 16'(fp))) ? bucket_hash(1, 16'(fp))
                                               : bucket_hash(0, 16'(fp));
         end
         return pkct_pkg::ST_GAVE_UP;
      endfunction

      function void note_word(pkct_pkg::action_type act, logic [31:0] key, logic [31:0] v);
         logic [pkct_pkg::FP_W-1:0]  fp;
         logic [pkct_pkg::BKT_W-1:0] b0, b1;
         int hit;
         rsp_word_type r;
         fp = bucket_hash(0, key[15:0]) ^ bucket_hash(1, key[31:16]);
         b0 = bucket_hash(0, 16'(fp));
         b1 = bucket_hash(1, 16'(fp));
         r.found_value = '0;
         if (act == pkct_pkg::ACT_INSERT) begin
            r.status = insert_key(b0, b1, fp, v);
         end else begin
            hit = find_slot(b0, b1, fp);
            if (hit < 0) begin
               r.status = pkct_pkg::ST_NOT_FOUND;
            end else begin
               r.status = pkct_pkg::ST_OK;
               case (act)
                  pkct_pkg::ACT_DELETE: slot_valid[hit] = 0;
                  pkct_pkg::ACT_LOOKUP: r.found_value = slot_value[hit];
                  default:              slot_value[hit] = v;
               endcase
            end
         end
         expected_rsp.push_back(r);
      endfunction

      function void check_result(logic [1:0] status, logic [31:0] found_value);
         rsp_word_type r;
         if (expected_rsp.size() == 0) begin
            $error("unexpected response word: status %0d found_value %h", status, found_value);
            errors++;
            return;
         end
         r = expected_rsp.pop_front();
         if (status !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, status);
            errors++;
         end
         if (found_value !== r.found_value) begin
            $error("found_value: expected %h, actual %h", r.found_value, found_value);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [pkct_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pkct_pkg::CSR_DATA_W-1:0] csr_wdata;
   bit calm;

   pkct_req_if req_if ();
   pkct_rsp_if rsp_if ();

   partial_key_cuckoo_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if.sink),
      .rsp_ch    (rsp_if.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cuckoo_mirror mirror = new();
   logic [31:0] key_pool [$];

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(64'd60_000_000);
      $display("simulation failed");
      $finish;
   end

   // Response side: ready comes and goes in bursts unless the run is in its calm tail.
   initial begin
      rsp_if.ready <= 0;
      @(posedge clock);
      forever begin
         rsp_if.ready <= 1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!calm) begin
            rsp_if.ready <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_if.valid && rsp_if.ready)
         mirror.check_result(rsp_if.status, rsp_if.found_value);

   task automatic write_regs(logic [pkct_pkg::KICK_W-1:0] kick, bit eager,
                             logic [pkct_pkg::SEED_W-1:0] seed);
      csr_wr_en <= 1;
      csr_index <= pkct_pkg::CSR_MAX_KICKOUTS;
      csr_wdata <= pkct_pkg::CSR_DATA_W'(kick);
      mirror.set_reg(pkct_pkg::CSR_MAX_KICKOUTS, pkct_pkg::CSR_DATA_W'(kick));
      @(posedge clock);
      csr_index <= pkct_pkg::CSR_FAIL_EAGERLY;
      csr_wdata <= pkct_pkg::CSR_DATA_W'(eager);
      mirror.set_reg(pkct_pkg::CSR_FAIL_EAGERLY, pkct_pkg::CSR_DATA_W'(eager));
      @(posedge clock);
      csr_index <= pkct_pkg::CSR_RANDOM_SEED;
      csr_wdata <= seed;
      mirror.set_reg(pkct_pkg::CSR_RANDOM_SEED, seed);
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic send_word(pkct_pkg::action_type act, logic [31:0] key, logic [31:0] v);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid     <= 1;
      req_if.action    <= act;
      req_if.item_key  <= key;
      req_if.new_value <= v;
      do @(posedge clock); while (!req_if.ready);
      mirror.note_word(act, key, v);
   endtask

   // Lower valid and hold off until every outstanding response has come back.
   task automatic drain();
      req_if.valid <= 0;
      while (mirror.pending() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send_random(int count, int insert_pct);
      pkct_pkg::action_type act;
      logic [31:0] key;
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < insert_pct) act = pkct_pkg::ACT_INSERT;
         else if (roll < insert_pct + (100 - insert_pct) / 3) act = pkct_pkg::ACT_DELETE;
         else if (roll < insert_pct + 2 * (100 - insert_pct) / 3) act = pkct_pkg::ACT_LOOKUP;
         else act = pkct_pkg::ACT_UPDATE;
         if (key_pool.size() > 0 && $urandom_range(0, 1) == 1)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
         else
            key = $urandom;
         if (act == pkct_pkg::ACT_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > 64) void'(key_pool.pop_front());
         end
         send_word(act, key, $urandom);
      end
   endtask

   initial begin
      reset        <= 1;
      csr_wr_en    <= 0;
      csr_index    <= pkct_pkg::CSR_MAX_KICKOUTS;
      csr_wdata    <= '0;
      req_if.valid <= 0;
      req_if.action    <= pkct_pkg::ACT_INSERT;
      req_if.item_key  <= '0;
      req_if.new_value <= '0;
      calm = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed words under the reset configuration.
      send_word(pkct_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h1234_5678);
      send_word(pkct_pkg::ACT_DELETE, 32'hFFFF_FFFF, 32'h0);
      send_word(pkct_pkg::ACT_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(pkct_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_word(pkct_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(pkct_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0);
      send_word(pkct_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_word(pkct_pkg::ACT_UPDATE, 32'h0000_0000, 32'hA5A5_5A5A);
      send_word(pkct_pkg::ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(pkct_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0F0F_F0F0);
      send_word(pkct_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_word(pkct_pkg::ACT_DELETE, 32'hFFFF_FFFF, 32'h0);
      send_word(pkct_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_word(pkct_pkg::ACT_DELETE, 32'hFFFF_FFFF, 32'h0);
      send_word(pkct_pkg::ACT_INSERT, 32'h8000_0001, 32'h8000_0000);
      send_word(pkct_pkg::ACT_LOOKUP, 32'h8000_0001, 32'h0);
      send_word(pkct_pkg::ACT_INSERT, 32'h0001_8000, 32'h0000_0001);
      send_word(pkct_pkg::ACT_LOOKUP, 32'h0001_8000, 32'h0);
      drain();

      // Full buckets fail at once.
      write_regs(10'd0, 1'b1, 16'd1);
      send_random(90, 85);
      drain();

      // A zero kickout limit gives up without writing.
      write_regs(10'd0, 1'b0, 16'd44257);
      send_random(70, 70);
      drain();

      // Largest kickout limit; a pause for all responses midway.
      write_regs(10'd1023, 1'b0, 16'd65535);
      send_random(60, 60);
      drain();
      send_random(60, 55);
      drain();

      // A zero seed freezes the victim choice.
      write_regs(10'd3, 1'b0, 16'd0);
      send_random(80, 60);
      drain();

      write_regs(10'($urandom_range(1, 40)), 1'b0, 16'($urandom_range(1, 65535)));
      send_random(70, 50);
      calm = 1;
      send_random(70, 50);
      drain();

      if (mirror.errors == 0 && mirror.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== partial_key_cuckoo_table.f =====
sv/pkct_pkg.sv
sv/pkct_req_if.sv
sv/pkct_rsp_if.sv
sv/partial_key_cuckoo_table.sv
dv/tb.sv
